FILE: hdl/assert_macros.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_PROP_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_PROP_NR(lbl, clk, prop)
`endif

`endif

FILE: hdl/cst_pkg.sv
// Types and constants shared by the tokenizer modules.
`timescale 1ns / 1ps

package cst_pkg;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned KIND_W = 5;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned RUN_MAX = 3;

  localparam longint unsigned MAX_TEXT_LENGTH = 64'd65536;
  localparam logic [POS_W-1:0] OFFSET_CAP =
    (MAX_TEXT_LENGTH - 64'd1 > 64'd65535) ? 16'hFFFF : 16'(MAX_TEXT_LENGTH - 64'd1);
  localparam logic [POS_W-1:0] POS_CAP = 16'hFFFF;

  localparam logic [KIND_W-1:0] K_ARROW     = 5'd0;
  localparam logic [KIND_W-1:0] K_IDENT     = 5'd1;
  localparam logic [KIND_W-1:0] K_INT       = 5'd2;
  localparam logic [KIND_W-1:0] K_REAL      = 5'd3;
  localparam logic [KIND_W-1:0] K_LT        = 5'd4;
  localparam logic [KIND_W-1:0] K_GT        = 5'd5;
  localparam logic [KIND_W-1:0] K_COLON     = 5'd6;
  localparam logic [KIND_W-1:0] K_SEMI      = 5'd7;
  localparam logic [KIND_W-1:0] K_LPAREN    = 5'd8;
  localparam logic [KIND_W-1:0] K_RPAREN    = 5'd9;
  localparam logic [KIND_W-1:0] K_LBRACK    = 5'd10;
  localparam logic [KIND_W-1:0] K_RBRACK    = 5'd11;
  localparam logic [KIND_W-1:0] K_COMMA     = 5'd12;
  localparam logic [KIND_W-1:0] K_PLUS      = 5'd13;
  localparam logic [KIND_W-1:0] K_MINUS     = 5'd14;
  localparam logic [KIND_W-1:0] K_STAR      = 5'd15;
  localparam logic [KIND_W-1:0] K_SLASH     = 5'd16;
  localparam logic [KIND_W-1:0] K_BAD_CHAR  = 5'd17;
  localparam logic [KIND_W-1:0] K_EXP_DIGIT = 5'd18;
  localparam logic [KIND_W-1:0] K_END       = 5'd19;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  start_off;
    logic [POS_W-1:0]  end_off;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
  } res_t;

  // all results caused by one request; cnt_m1 is count minus one
  typedef struct packed {
    res_t [RUN_MAX-1:0] res;
    logic [1:0]         cnt_m1;
  } run_t;

endpackage

FILE: hdl/cst_lexer.sv
// Lexer state, per-byte token decision and registered run of results.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cst_lexer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [cst_pkg::CHAR_W-1:0] in_character,
  input  logic                      in_end_marker,
  output logic                      run_vld,
  input  logic                      run_rdy,
  output cst_pkg::run_t             run
);
  import cst_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_INT, M_MINUS, M_MINUS2, M_POINT, M_REAL
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  set_start;
    logic  emit;
    logic  halt;
    res_t  res;
  } idle_t;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LBRK  = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRK  = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_SP    = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

  function automatic logic [POS_W-1:0] off_inc(input logic [POS_W-1:0] v);
    return (v >= OFFSET_CAP) ? OFFSET_CAP : v + 1'b1;
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic [KIND_W-1:0] symbol_kind(input logic [CHAR_W-1:0] c);
    logic [KIND_W-1:0] k;
    unique case (c)
      CH_LT:    k = K_LT;
      CH_GT:    k = K_GT;
      CH_COLON: k = K_COLON;
      CH_SEMI:  k = K_SEMI;
      CH_LPAR:  k = K_LPAREN;
      CH_RPAR:  k = K_RPAREN;
      CH_LBRK:  k = K_LBRACK;
      CH_RBRK:  k = K_RBRACK;
      CH_COMMA: k = K_COMMA;
      CH_PLUS:  k = K_PLUS;
      CH_MINUS: k = K_MINUS;
      CH_STAR:  k = K_STAR;
      CH_SLASH: k = K_SLASH;
      default:  k = K_ARROW;
    endcase
    return k;
  endfunction

  function automatic res_t mk_res(input logic [KIND_W-1:0] kind,
                                  input logic [POS_W-1:0] s, input logic [POS_W-1:0] e,
                                  input logic [POS_W-1:0] row, input logic [POS_W-1:0] col);
    res_t r;
    r.kind = kind;
    r.start_off = s;
    r.end_off = e;
    r.row = row;
    r.col = col;
    return r;
  endfunction

  // byte seen with no token pending
  function automatic idle_t idle_byte(input logic [CHAR_W-1:0] c, input logic [POS_W-1:0] o,
                                      input logic [POS_W-1:0] row,
                                      input logic [POS_W-1:0] col);
    idle_t r;
    logic [KIND_W-1:0] k;
    k = symbol_kind(c);
    r.mode = M_IDLE;
    r.set_start = 1'b0;
    r.emit = 1'b0;
    r.halt = 1'b0;
    r.res = mk_res(k, o, off_inc(o), '0, '0);
    if (c == CH_MINUS) begin
      r.mode = M_MINUS;
      r.set_start = 1'b1;
    end else if (is_letter(c)) begin
      r.mode = M_IDENT;
      r.set_start = 1'b1;
    end else if (is_digit(c)) begin
      r.mode = M_INT;
      r.set_start = 1'b1;
    end else if (k != K_ARROW) begin
      r.emit = 1'b1;
    end else if (!is_space(c)) begin
      r.emit = 1'b1;
      r.halt = 1'b1;
      r.res = mk_res(K_BAD_CHAR, o, off_inc(o), row, col);
    end
    return r;
  endfunction

  mode_t            mode_r, mode_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic [POS_W-1:0] off_r, off_nxt;
  logic [POS_W-1:0] line_r, line_nxt;
  logic [POS_W-1:0] col_r, col_nxt;
  logic             halt_r, halt_nxt;
  logic             run_vld_r;
  run_t             run_r;

  res_t [RUN_MAX-1:0] rs;
  logic [1:0]         n;
  idle_t              ib;
  logic               do_idle;
  logic [POS_W-1:0]   s2;
  logic               accept;

  assign in_ready = !run_vld_r || run_rdy;
  assign accept   = in_valid && in_ready;
  assign run_vld  = run_vld_r;
  assign run      = run_r;

  always_comb begin
    rs        = '0;
    n         = 2'd0;
    mode_nxt  = mode_r;
    start_nxt = start_r;
    off_nxt   = off_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    halt_nxt  = halt_r;
    do_idle   = 1'b0;
    s2        = off_inc(start_r);
    ib        = idle_byte(in_character, off_r, line_r, col_r);
    if (in_end_marker) begin
      if (!halt_r) begin
        unique case (mode_r)
          M_IDENT: begin
            rs[n] = mk_res(K_IDENT, start_r, off_r, '0, '0);
            n = n + 1'b1;
          end
          M_INT: begin
            rs[n] = mk_res(K_INT, start_r, off_r, '0, '0);
            n = n + 1'b1;
          end
          M_REAL: begin
            rs[n] = mk_res(K_REAL, start_r, off_r, '0, '0);
            n = n + 1'b1;
          end
          M_MINUS: begin
            rs[n] = mk_res(K_MINUS, start_r, s2, '0, '0);
            n = n + 1'b1;
          end
          M_MINUS2: begin
            rs[n] = mk_res(K_MINUS, start_r, s2, '0, '0);
            n = n + 1'b1;
            rs[n] = mk_res(K_MINUS, s2, off_inc(s2), '0, '0);
            n = n + 1'b1;
          end
          M_POINT: begin
            rs[n] = mk_res(K_EXP_DIGIT, off_r, off_r, line_r, col_r);
            n = n + 1'b1;
          end
          default: ;
        endcase
      end
      rs[n] = mk_res(K_END, off_r, off_r, '0, '0);
      n = n + 1'b1;
      mode_nxt  = M_IDLE;
      start_nxt = '0;
      off_nxt   = '0;
      line_nxt  = POS_W'(1);
      col_nxt   = POS_W'(1);
      halt_nxt  = 1'b0;
    end else if (!halt_r) begin
      unique case (mode_r)
        M_IDENT: begin
          if (!(is_letter(in_character) || is_digit(in_character))) begin
            rs[n] = mk_res(K_IDENT, start_r, off_r, '0, '0);
            n = n + 1'b1;
            do_idle = 1'b1;
          end
        end
        M_INT: begin
          if (in_character == CH_POINT) begin
            mode_nxt = M_POINT;
          end else if (!is_digit(in_character)) begin
            rs[n] = mk_res(K_INT, start_r, off_r, '0, '0);
            n = n + 1'b1;
            do_idle = 1'b1;
          end
        end
        M_REAL: begin
          if (!is_digit(in_character)) begin
            rs[n] = mk_res(K_REAL, start_r, off_r, '0, '0);
            n = n + 1'b1;
            do_idle = 1'b1;
          end
        end
        M_MINUS: begin
          if (is_digit(in_character)) begin
            mode_nxt = M_INT;
          end else if (in_character == CH_POINT) begin
            mode_nxt = M_POINT;
          end else if (in_character == CH_MINUS) begin
            mode_nxt = M_MINUS2;
          end else begin
            rs[n] = mk_res(K_MINUS, start_r, s2, '0, '0);
            n = n + 1'b1;
            do_idle = 1'b1;
          end
        end
        M_MINUS2: begin
          if (in_character == CH_GT) begin
            rs[n] = mk_res(K_ARROW, start_r, off_inc(off_r), '0, '0);
            n = n + 1'b1;
            mode_nxt = M_IDLE;
          end else begin
            rs[n] = mk_res(K_MINUS, start_r, s2, '0, '0);
            n = n + 1'b1;
            if (in_character == CH_MINUS) begin
              start_nxt = s2;
            end else if (is_digit(in_character)) begin
              start_nxt = s2;
              mode_nxt = M_INT;
            end else if (in_character == CH_POINT) begin
              start_nxt = s2;
              mode_nxt = M_POINT;
            end else begin
              rs[n] = mk_res(K_MINUS, s2, off_inc(s2), '0, '0);
              n = n + 1'b1;
              do_idle = 1'b1;
            end
          end
        end
        M_POINT: begin
          if (is_digit(in_character)) begin
            mode_nxt = M_REAL;
          end else begin
            rs[n] = mk_res(K_EXP_DIGIT, off_r, off_inc(off_r), line_r, col_r);
            n = n + 1'b1;
            halt_nxt = 1'b1;
            mode_nxt = M_IDLE;
          end
        end
        default: do_idle = 1'b1;
      endcase
      if (do_idle) begin
        mode_nxt = ib.mode;
        if (ib.set_start) begin
          start_nxt = off_r;
        end
        if (ib.emit) begin
          rs[n] = ib.res;
          n = n + 1'b1;
        end
        if (ib.halt) begin
          halt_nxt = 1'b1;
        end
      end
      off_nxt = off_inc(off_r);
      if (in_character == CH_LF) begin
        if (line_r < POS_CAP) begin
          line_nxt = line_r + 1'b1;
        end
        col_nxt = POS_W'(1);
      end else if (col_r < POS_CAP) begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_IDLE;
      start_r   <= '0;
      off_r     <= '0;
      line_r    <= POS_W'(1);
      col_r     <= POS_W'(1);
      halt_r    <= 1'b0;
      run_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        mode_r       <= mode_nxt;
        start_r      <= start_nxt;
        off_r        <= off_nxt;
        line_r       <= line_nxt;
        col_r        <= col_nxt;
        halt_r       <= halt_nxt;
        run_vld_r    <= (n != 2'd0);
        run_r.res    <= rs;
        run_r.cnt_m1 <= n - 1'b1;
      end else if (run_rdy) begin
        run_vld_r <= 1'b0;
      end
    end
  end

  `ASSERT_PROP(a_halt_idle, clk, rst_n, halt_r |-> (mode_r == M_IDLE))
  `ASSERT_PROP(a_end_clears, clk, rst_n,
    (accept && in_end_marker) |=> (line_r == POS_W'(1) && col_r == POS_W'(1) && !halt_r))
  `ASSERT_PROP(a_off_cap, clk, rst_n, (off_r <= OFFSET_CAP) && (line_r != '0) && (col_r != '0))

endmodule

FILE: hdl/cst_run_fifo.sv
// Queue of result runs, drained one result per request on the output side.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cst_run_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_vld,
  output logic            wr_rdy,
  input  cst_pkg::run_t   wr_run,
  output logic            out_valid,
  input  logic            out_ready,
  output cst_pkg::res_t   out_res,
  output logic            out_last
);
  import cst_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  run_t          mem_r [DEPTH];
  logic [PW-1:0] wptr_r;
  logic [PW-1:0] rptr_r;
  logic [CW-1:0] cnt_r;
  logic [1:0]    sub_r;
  run_t          head;
  logic          push;
  logic          pop;
  logic          take;

  assign wr_rdy    = (cnt_r != CW'(DEPTH));
  assign push      = wr_vld && wr_rdy;
  assign head      = mem_r[rptr_r];
  assign out_valid = (cnt_r != '0);
  assign out_res   = head.res[sub_r];
  assign out_last  = (sub_r == head.cnt_m1);
  assign take      = out_valid && out_ready;
  assign pop       = take && out_last;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
      sub_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (take) begin
        sub_r <= out_last ? 2'd0 : sub_r + 1'b1;
      end
    end
  end

  `ASSERT_PROP(a_cnt_bound, clk, rst_n, cnt_r <= CW'(DEPTH))
  `ASSERT_PROP(a_sub_in_run, clk, rst_n, out_valid |-> (sub_r <= head.cnt_m1))
  `ASSERT_PROP(a_sub_empty, clk, rst_n, (cnt_r == '0) |-> (sub_r == 2'd0))

endmodule

FILE: hdl/char_stream_tokenizer_core.sv
// Streaming tokenizer top level: lexer stage feeding a result-run queue.
// A request's results are registered in the lexer stage, then queued. Throughput:
// one request per cycle while the queue has room; each request yields 0 to 3 results
// and the output port, one result per cycle when ready, sets the sustained rate.
// Queue holds RUN_DEPTH runs; the input stalls only when it and the stage are full.
// Reset (rst_n low, synchronous) clears lexer state and empties the queue.
`timescale 1ns / 1ps

module char_stream_tokenizer_core #(
  parameter int unsigned RUN_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cst_pkg::CHAR_W-1:0]  in_character,
  input  logic                        in_end_marker,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cst_pkg::KIND_W-1:0]  out_token_kind,
  output logic [cst_pkg::POS_W-1:0]   out_start_offset,
  output logic [cst_pkg::POS_W-1:0]   out_end_offset,
  output logic [cst_pkg::POS_W-1:0]   out_error_row,
  output logic [cst_pkg::POS_W-1:0]   out_error_column,
  output logic                        out_last_of_run
);
  import cst_pkg::*;

  logic run_vld;
  logic run_rdy;
  run_t run;
  res_t res;

  cst_lexer u_lexer (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_character  (in_character),
    .in_end_marker (in_end_marker),
    .run_vld       (run_vld),
    .run_rdy       (run_rdy),
    .run           (run)
  );

  cst_run_fifo #(
    .DEPTH (RUN_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_vld    (run_vld),
    .wr_rdy    (run_rdy),
    .wr_run    (run),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res),
    .out_last  (out_last_of_run)
  );

  assign out_token_kind   = res.kind;
  assign out_start_offset = res.start_off;
  assign out_end_offset   = res.end_off;
  assign out_error_row    = res.row;
  assign out_error_column = res.col;

endmodule

FILE: tb/char_stream_tokenizer_core_tb.sv
// Self-checking testbench for char_stream_tokenizer_core with an inline token predictor.
`timescale 1ns / 1ps

module char_stream_tokenizer_core_tb;
  import cst_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned LONG_RUN       = 40;

  typedef enum logic [3:0] {
    LX_IDLE, LX_IDENT, LX_INT, LX_MINUS, LX_MINUS2, LX_POINT, LX_REAL
  } lx_mode_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  start_off;
    logic [POS_W-1:0]  end_off;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic              last;
  } tok_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CHAR_W-1:0] in_character = '0;
  logic              in_end_marker = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [KIND_W-1:0] out_token_kind;
  logic [POS_W-1:0]  out_start_offset;
  logic [POS_W-1:0]  out_end_offset;
  logic [POS_W-1:0]  out_error_row;
  logic [POS_W-1:0]  out_error_column;
  logic              out_last_of_run;

  char_stream_tokenizer_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_character     (in_character),
    .in_end_marker    (in_end_marker),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_start_offset (out_start_offset),
    .out_end_offset   (out_end_offset),
    .out_error_row    (out_error_row),
    .out_error_column (out_error_column),
    .out_last_of_run  (out_last_of_run)
  );

  always #5 clk = ~clk;

  // predictor state
  lx_mode_t         lx_mode;
  logic [POS_W-1:0] tok_start;
  logic [POS_W-1:0] cur_off;
  logic [POS_W-1:0] line_no;
  logic [POS_W-1:0] col_no;
  logic             halted;

  tok_t        step_tokens[$];
  tok_t        pending_tokens[$];
  int unsigned mismatches = 0;
  int unsigned lexed_bytes = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  string sym_chars  = "<>:;()[],+-*/";
  string ws_chars   = " \t\n\r";
  string minus_tail = ">-.5x ;";

  function automatic logic [POS_W-1:0] bump_off(logic [POS_W-1:0] v);
    return (v >= OFFSET_CAP) ? OFFSET_CAP : v + 16'd1;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == " " || c == "\t" || c == "\n" || c == "\r";
  endfunction

  // K_BAD_CHAR means the byte is not a one-character symbol
  function automatic logic [KIND_W-1:0] sym_kind(logic [7:0] c);
    case (c)
      "<": return K_LT;
      ">": return K_GT;
      ":": return K_COLON;
      ";": return K_SEMI;
      "(": return K_LPAREN;
      ")": return K_RPAREN;
      "[": return K_LBRACK;
      "]": return K_RBRACK;
      ",": return K_COMMA;
      "+": return K_PLUS;
      "-": return K_MINUS;
      "*": return K_STAR;
      "/": return K_SLASH;
      default: return K_BAD_CHAR;
    endcase
  endfunction

  function automatic logic [7:0] rand_letter();
    return 8'("A" + $urandom_range(0, 25) + ($urandom_range(0, 1) ? 32 : 0));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  task automatic lexer_reset();
    lx_mode = LX_IDLE;
    tok_start = '0;
    cur_off = '0;
    line_no = 16'd1;
    col_no = 16'd1;
    halted = 1'b0;
  endtask

  task automatic emit_tok(logic [KIND_W-1:0] k, logic [POS_W-1:0] s, logic [POS_W-1:0] e,
                          logic [POS_W-1:0] r, logic [POS_W-1:0] cl);
    tok_t t;
    t.kind = k;
    t.start_off = s;
    t.end_off = e;
    t.row = r;
    t.col = cl;
    t.last = 1'b0;
    step_tokens = {step_tokens, t};
  endtask

  task automatic emit_minus(logic [POS_W-1:0] s);
    emit_tok(K_MINUS, s, bump_off(s), '0, '0);
  endtask

  task automatic start_from_idle(logic [7:0] c, logic [POS_W-1:0] o);
    logic [KIND_W-1:0] k;
    k = sym_kind(c);
    lx_mode = LX_IDLE;
    if (c == "-") begin
      lx_mode = LX_MINUS;
      tok_start = o;
    end else if (is_letter(c)) begin
      lx_mode = LX_IDENT;
      tok_start = o;
    end else if (is_digit(c)) begin
      lx_mode = LX_INT;
      tok_start = o;
    end else if (k != K_BAD_CHAR) begin
      emit_tok(k, o, bump_off(o), '0, '0);
    end else if (!is_space(c)) begin
      emit_tok(K_BAD_CHAR, o, bump_off(o), line_no, col_no);
      halted = 1'b1;
    end
  endtask

  // expected tokens for one accepted request
  task automatic tokenize_byte(logic [7:0] c, logic em);
    logic [POS_W-1:0] o;
    logic [POS_W-1:0] s2;
    o = cur_off;
    s2 = bump_off(tok_start);
    step_tokens = {};
    if (em) begin
      if (!halted) begin
        case (lx_mode)
          LX_IDENT: emit_tok(K_IDENT, tok_start, o, '0, '0);
          LX_INT:   emit_tok(K_INT, tok_start, o, '0, '0);
          LX_REAL:  emit_tok(K_REAL, tok_start, o, '0, '0);
          LX_MINUS: emit_minus(tok_start);
          LX_MINUS2: begin
            emit_minus(tok_start);
            emit_minus(s2);
          end
          LX_POINT: emit_tok(K_EXP_DIGIT, o, o, line_no, col_no);
          default: ;
        endcase
      end
      emit_tok(K_END, o, o, '0, '0);
      lexer_reset();
    end else if (!halted) begin
      case (lx_mode)
        LX_IDENT: begin
          if (!(is_letter(c) || is_digit(c))) begin
            emit_tok(K_IDENT, tok_start, o, '0, '0);
            start_from_idle(c, o);
          end
        end
        LX_INT: begin
          if (c == ".") begin
            lx_mode = LX_POINT;
          end else if (!is_digit(c)) begin
            emit_tok(K_INT, tok_start, o, '0, '0);
            start_from_idle(c, o);
          end
        end
        LX_REAL: begin
          if (!is_digit(c)) begin
            emit_tok(K_REAL, tok_start, o, '0, '0);
            start_from_idle(c, o);
          end
        end
        LX_MINUS: begin
          if (is_digit(c)) begin
            lx_mode = LX_INT;
          end else if (c == ".") begin
            lx_mode = LX_POINT;
          end else if (c == "-") begin
            lx_mode = LX_MINUS2;
          end else begin
            emit_minus(tok_start);
            start_from_idle(c, o);
          end
        end
        LX_MINUS2: begin
          if (c == ">") begin
            emit_tok(K_ARROW, tok_start, bump_off(o), '0, '0);
            lx_mode = LX_IDLE;
          end else if (c == "-") begin
            emit_minus(tok_start);
            tok_start = s2;
          end else if (is_digit(c)) begin
            emit_minus(tok_start);
            tok_start = s2;
            lx_mode = LX_INT;
          end else if (c == ".") begin
            emit_minus(tok_start);
            tok_start = s2;
            lx_mode = LX_POINT;
          end else begin
            emit_minus(tok_start);
            emit_minus(s2);
            start_from_idle(c, o);
          end
        end
        LX_POINT: begin
          if (is_digit(c)) begin
            lx_mode = LX_REAL;
          end else begin
            emit_tok(K_EXP_DIGIT, o, bump_off(o), line_no, col_no);
            halted = 1'b1;
            lx_mode = LX_IDLE;
          end
        end
        default: start_from_idle(c, o);
      endcase
      cur_off = bump_off(o);
      if (c == "\n") begin
        if (line_no < POS_CAP) line_no = line_no + 16'd1;
        col_no = 16'd1;
      end else if (col_no < POS_CAP) begin
        col_no = col_no + 16'd1;
      end
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
    pending_tokens = {pending_tokens, step_tokens};
  endtask

  // one request: optional random gap, then hold until accepted
  task automatic send_byte(logic [7:0] c, logic em);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_character <= c;
    in_end_marker <= em;
    do @(posedge clk); while (!in_ready);
    if (!halted || em) lexed_bytes++;
    tokenize_byte(c, em);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_byte(s[i], 1'b0);
  endtask

  task automatic send_random_text();
    int unsigned pick;
    repeat ($urandom_range(1, 8)) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_byte(rand_letter(), 1'b0);
        repeat ($urandom_range(0, 5))
          send_byte($urandom_range(0, 1) ? rand_letter() : rand_digit(), 1'b0);
      end else if (pick < 50) begin
        if ($urandom_range(0, 1)) send_byte("-", 1'b0);
        repeat ($urandom_range(1, 4)) send_byte(rand_digit(), 1'b0);
        if ($urandom_range(0, 2) == 0) begin
          send_byte(".", 1'b0);
          repeat ($urandom_range(0, 3)) send_byte(rand_digit(), 1'b0);
        end
      end else if (pick < 58) begin
        send_text("-->");
      end else if (pick < 72) begin
        send_byte(sym_chars[$urandom_range(0, sym_chars.len()-1)], 1'b0);
      end else if (pick < 84) begin
        send_byte(ws_chars[$urandom_range(0, 3)], 1'b0);
      end else if (pick < 93) begin
        repeat ($urandom_range(1, 3)) send_byte("-", 1'b0);
        send_byte(minus_tail[$urandom_range(0, minus_tail.len()-1)], 1'b0);
      end else if (pick < 96) begin
        send_byte(".", 1'b0);
      end else begin
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      if ($urandom_range(0, 1)) send_byte(ws_chars[$urandom_range(0, 3)], 1'b0);
    end
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_symbols();
    send_text("<>:;()[],+*/");
    send_byte(8'hFF, 1'b1);
  endtask

  // arrow, identifier, real, double minus before a digit, integer flushed at end
  task automatic test_numbers();
    send_text("-->a9-5.2--7");
    send_byte(8'h00, 1'b1);
  endtask

  // point pending at end of text; zero byte as bad character
  task automatic test_errors();
    send_text("3.");
    send_byte("x", 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte("a", 1'b1);
  endtask

  // offsets and column grow along one long line, row over many short ones
  task automatic test_long_lines();
    repeat (LONG_RUN) send_byte(" ", 1'b0);
    send_text("ab--x$");
    send_byte(" ", 1'b1);
    repeat (LONG_RUN) send_byte("\n", 1'b0);
    send_text("q#");
    send_byte(" ", 1'b1);
  endtask

  task automatic test_random_texts(int unsigned n_bytes);
    int unsigned base;
    base = lexed_bytes;
    while (lexed_bytes - base < n_bytes) send_random_text();
  endtask

  task automatic check_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    tok_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_tokens.size() == 0) begin
        $error("unexpected result: kind %0d, start %0d", out_token_kind, out_start_offset);
        mismatches++;
      end else begin
        want = pending_tokens.pop_front();
        check_field("token_kind", 16'(want.kind), 16'(out_token_kind));
        check_field("start_offset", want.start_off, out_start_offset);
        check_field("end_offset", want.end_off, out_end_offset);
        check_field("error_row", want.row, out_error_row);
        check_field("error_column", want.col, out_error_column);
        check_field("last_of_run", 16'(want.last), 16'(out_last_of_run));
      end
    end
    out_ready <= rst_n && ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    lexer_reset();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_symbols();
    test_numbers();
    test_errors();
    test_long_lines();

    tx_idle_pct = 55;
    test_random_texts(25);
    tx_idle_pct = 0;
    rx_stall_pct = 55;
    test_random_texts(25);
    tx_idle_pct = 25;
    rx_stall_pct = 25;
    test_random_texts(25);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    test_random_texts(25);

    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
